FILE: rtl/imu_srs_pkg.sv
// shared types and constants for the imu spi read scheduler
// no dependencies; used by imu_spi_read_scheduler_top
package imu_srs_pkg;

  // event codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_ACCEL_IRQ = 2'd0,
    MODE_GYRO_IRQ  = 2'd1,
    MODE_XFER_DONE = 2'd2,
    MODE_CONSUME   = 2'd3
  } mode_e;

  // source codes reported with a started transfer
  localparam logic [1:0] SRC_GYRO  = 2'd0;
  localparam logic [1:0] SRC_ACCEL = 2'd1;
  localparam logic [1:0] SRC_TEMP  = 2'd2;

  // register read commands
  localparam logic [7:0] CMD_GYRO  = 8'h82;
  localparam logic [7:0] CMD_ACCEL = 8'h92;
  localparam logic [7:0] CMD_TEMP  = 8'hA2;

  // read lengths in bytes
  localparam logic [3:0] GYRO_READ_BYTES  = 4'd8;
  localparam logic [3:0] ACCEL_READ_BYTES = 4'd9;
  localparam logic [3:0] TEMP_READ_BYTES  = 4'd4;

  // stage bit positions
  localparam int unsigned ST_PEND = 0;
  localparam int unsigned ST_XFER = 1;
  localparam int unsigned ST_UPD  = 2;
  localparam int unsigned ST_NOTE = 3;

  // chip select bit positions
  localparam int unsigned SEL_GYRO  = 0;
  localparam int unsigned SEL_ACCEL = 1;

  typedef struct packed {
    logic       start_valid;
    logic [1:0] start_source;
    logic [7:0] command_byte;
    logic [3:0] transfer_length;
    logic       gyro_select_active;
    logic       accel_select_active;
    logic       wake_task;
    logic       gyro_delivered;
    logic       accel_delivered;
    logic       temp_delivered;
  } result_t;

endpackage

FILE: rtl/imu_spi_read_scheduler_top.sv
// imu spi read scheduler: per-source stage tracking and spi read start decisions
// depends on imu_srs_pkg
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries one event per request:
//   mode_i selects accel irq, gyro irq, transfer complete or task consume,
//   link_busy_i reports whether the external dma is still running.
//   output channel (out_valid_o / out_stall_i) returns exactly one result
//   per event: start decision, command byte, length, chip selects after the
//   event, task wake and delivery flags.
//   cfg_we_i / cfg_wdata_i write scheduling_enabled; write only while idle.
// timing and throughput:
//   the result appears in the cycle after the event is taken. one event per
//   cycle with out_stall_i low; the single result register is the limit.
// reset:
//   all stage bits clear, both chip selects released, scheduling disabled,
//   output register empty.
// stall:
//   while a result waits with out_stall_i high, in_stall_o is raised and
//   no new event is taken; the waiting result holds steady.
module imu_spi_read_scheduler_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic       link_busy_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       start_valid_o,
  output logic [1:0] start_source_o,
  output logic [7:0] command_byte_o,
  output logic [3:0] transfer_length_o,
  output logic       gyro_select_active_o,
  output logic       accel_select_active_o,
  output logic       wake_task_o,
  output logic       gyro_delivered_o,
  output logic       accel_delivered_o,
  output logic       temp_delivered_o
);

  logic [3:0] gyro_q, gyro_d;
  logic [2:0] accel_q, accel_d;
  logic [2:0] temp_q, temp_d;
  logic [1:0] sel_q, sel_d;
  logic       sched_en_q;
  logic       out_valid_q;
  imu_srs_pkg::result_t res_q, res_d;
  logic       in_acc;
  logic       do_sched;
  imu_srs_pkg::mode_e mode;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign mode       = imu_srs_pkg::mode_e'(mode_i);

  always_comb begin
    gyro_d   = gyro_q;
    accel_d  = accel_q;
    temp_d   = temp_q;
    sel_d    = sel_q;
    res_d    = '0;
    do_sched = 1'b0;

    // event-specific updates before scheduling
    case (mode)
      imu_srs_pkg::MODE_ACCEL_IRQ: begin
        accel_d[imu_srs_pkg::ST_PEND] = 1'b1;
        temp_d[imu_srs_pkg::ST_PEND]  = 1'b1;
        do_sched = sched_en_q;
      end
      imu_srs_pkg::MODE_GYRO_IRQ: begin
        gyro_d[imu_srs_pkg::ST_PEND] = 1'b1;
        do_sched = sched_en_q;
      end
      imu_srs_pkg::MODE_XFER_DONE: begin
        if (gyro_q[imu_srs_pkg::ST_XFER]) begin
          gyro_d[imu_srs_pkg::ST_XFER]  = 1'b0;
          gyro_d[imu_srs_pkg::ST_UPD]   = 1'b1;
          sel_d[imu_srs_pkg::SEL_GYRO]  = 1'b0;
        end
        if (accel_q[imu_srs_pkg::ST_XFER]) begin
          accel_d[imu_srs_pkg::ST_XFER] = 1'b0;
          accel_d[imu_srs_pkg::ST_UPD]  = 1'b1;
          sel_d[imu_srs_pkg::SEL_ACCEL] = 1'b0;
        end
        if (temp_q[imu_srs_pkg::ST_XFER]) begin
          temp_d[imu_srs_pkg::ST_XFER]  = 1'b0;
          temp_d[imu_srs_pkg::ST_UPD]   = 1'b1;
          sel_d[imu_srs_pkg::SEL_ACCEL] = 1'b0;
        end
        do_sched = 1'b1;
      end
      imu_srs_pkg::MODE_CONSUME: begin
        if (gyro_q[imu_srs_pkg::ST_NOTE]) begin
          gyro_d[imu_srs_pkg::ST_NOTE] = 1'b0;
          res_d.gyro_delivered = 1'b1;
        end
        if (accel_q[imu_srs_pkg::ST_UPD]) begin
          accel_d[imu_srs_pkg::ST_UPD] = 1'b0;
          res_d.accel_delivered = 1'b1;
        end
        if (temp_q[imu_srs_pkg::ST_UPD]) begin
          temp_d[imu_srs_pkg::ST_UPD] = 1'b0;
          res_d.temp_delivered = 1'b1;
        end
      end
      default: ;
    endcase

    // fixed priority start while link_busy_i is low; only the other sources' transfers block a source
    if (do_sched && !link_busy_i) begin
      if (gyro_d[imu_srs_pkg::ST_PEND] && !accel_d[imu_srs_pkg::ST_XFER]
          && !temp_d[imu_srs_pkg::ST_XFER]) begin
        gyro_d[imu_srs_pkg::ST_PEND] = 1'b0;
        gyro_d[imu_srs_pkg::ST_XFER] = 1'b1;
        sel_d[imu_srs_pkg::SEL_GYRO] = 1'b1;
        res_d.start_valid     = 1'b1;
        res_d.start_source    = imu_srs_pkg::SRC_GYRO;
        res_d.command_byte    = imu_srs_pkg::CMD_GYRO;
        res_d.transfer_length = imu_srs_pkg::GYRO_READ_BYTES;
      end else if (accel_d[imu_srs_pkg::ST_PEND] && !gyro_d[imu_srs_pkg::ST_XFER]
                   && !temp_d[imu_srs_pkg::ST_XFER]) begin
        accel_d[imu_srs_pkg::ST_PEND] = 1'b0;
        accel_d[imu_srs_pkg::ST_XFER] = 1'b1;
        sel_d[imu_srs_pkg::SEL_ACCEL] = 1'b1;
        res_d.start_valid     = 1'b1;
        res_d.start_source    = imu_srs_pkg::SRC_ACCEL;
        res_d.command_byte    = imu_srs_pkg::CMD_ACCEL;
        res_d.transfer_length = imu_srs_pkg::ACCEL_READ_BYTES;
      end else if (temp_d[imu_srs_pkg::ST_PEND] && !gyro_d[imu_srs_pkg::ST_XFER]
                   && !accel_d[imu_srs_pkg::ST_XFER]) begin
        temp_d[imu_srs_pkg::ST_PEND]  = 1'b0;
        temp_d[imu_srs_pkg::ST_XFER]  = 1'b1;
        sel_d[imu_srs_pkg::SEL_ACCEL] = 1'b1;
        res_d.start_valid     = 1'b1;
        res_d.start_source    = imu_srs_pkg::SRC_TEMP;
        res_d.command_byte    = imu_srs_pkg::CMD_TEMP;
        res_d.transfer_length = imu_srs_pkg::TEMP_READ_BYTES;
      end
    end

    // finished gyro read wakes the task, after scheduling
    if (mode == imu_srs_pkg::MODE_XFER_DONE && gyro_d[imu_srs_pkg::ST_UPD]) begin
      gyro_d[imu_srs_pkg::ST_UPD] = 1'b0;
      gyro_d[imu_srs_pkg::ST_NOTE] = 1'b1;
      res_d.wake_task = 1'b1;
    end

    res_d.gyro_select_active  = sel_d[imu_srs_pkg::SEL_GYRO];
    res_d.accel_select_active = sel_d[imu_srs_pkg::SEL_ACCEL];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_q      <= '0;
      accel_q     <= '0;
      temp_q      <= '0;
      sel_q       <= '0;
      sched_en_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sched_en_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        gyro_q      <= gyro_d;
        accel_q     <= accel_d;
        temp_q      <= temp_d;
        sel_q       <= sel_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign start_valid_o         = res_q.start_valid;
  assign start_source_o        = res_q.start_source;
  assign command_byte_o        = res_q.command_byte;
  assign transfer_length_o     = res_q.transfer_length;
  assign gyro_select_active_o  = res_q.gyro_select_active;
  assign accel_select_active_o = res_q.accel_select_active;
  assign wake_task_o           = res_q.wake_task;
  assign gyro_delivered_o      = res_q.gyro_delivered;
  assign accel_delivered_o     = res_q.accel_delivered;
  assign temp_delivered_o      = res_q.temp_delivered;

  // at most one source owns the link
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({gyro_q[imu_srs_pkg::ST_XFER], accel_q[imu_srs_pkg::ST_XFER],
              temp_q[imu_srs_pkg::ST_XFER]}))
    else $error("more than one source transferring");

  // chip selects track the transferring stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q[imu_srs_pkg::SEL_GYRO] == gyro_q[imu_srs_pkg::ST_XFER]) &&
    (sel_q[imu_srs_pkg::SEL_ACCEL] ==
     (accel_q[imu_srs_pkg::ST_XFER] | temp_q[imu_srs_pkg::ST_XFER])))
    else $error("chip select out of step with transfer stage");

  // every taken event yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("result missing after accepted request");

  // a started transfer always carries a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.start_valid) |-> (res_q.transfer_length != 4'd0))
    else $error("started transfer without length");

endmodule

FILE: tb/imu_srs_tb_pkg.sv
`timescale 1ns / 1ps
// read scheduling scoreboard: tracks per-source stage bits and chip selects,
// predicts one result per accepted event. depends on imu_srs_pkg
package imu_srs_tb_pkg;

  class read_sched_scoreboard;
    logic [3:0]           gyro_st;
    logic [2:0]           accel_st;
    logic [2:0]           temp_st;
    logic                 gyro_cs;
    logic                 accel_cs;
    logic                 sched_en;
    imu_srs_pkg::result_t expected_q[$];
    int unsigned          errors;
    int unsigned          checked;

    function new();
      gyro_st  = '0;
      accel_st = '0;
      temp_st  = '0;
      gyro_cs  = 1'b0;
      accel_cs = 1'b0;
      sched_en = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) begin
        $display("ERROR @%0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    // fixed priority gyro, accel, temp when not busy; only other sources in flight block a start
    function void try_start(logic busy, inout imu_srs_pkg::result_t r);
      if (busy) return;
      if (gyro_st[imu_srs_pkg::ST_PEND] && !accel_st[imu_srs_pkg::ST_XFER]
          && !temp_st[imu_srs_pkg::ST_XFER]) begin
        gyro_st[imu_srs_pkg::ST_PEND] = 1'b0;
        gyro_st[imu_srs_pkg::ST_XFER] = 1'b1;
        gyro_cs           = 1'b1;
        r.start_valid     = 1'b1;
        r.start_source    = imu_srs_pkg::SRC_GYRO;
        r.command_byte    = imu_srs_pkg::CMD_GYRO;
        r.transfer_length = imu_srs_pkg::GYRO_READ_BYTES;
      end else if (accel_st[imu_srs_pkg::ST_PEND] && !gyro_st[imu_srs_pkg::ST_XFER]
                   && !temp_st[imu_srs_pkg::ST_XFER]) begin
        accel_st[imu_srs_pkg::ST_PEND] = 1'b0;
        accel_st[imu_srs_pkg::ST_XFER] = 1'b1;
        accel_cs          = 1'b1;
        r.start_valid     = 1'b1;
        r.start_source    = imu_srs_pkg::SRC_ACCEL;
        r.command_byte    = imu_srs_pkg::CMD_ACCEL;
        r.transfer_length = imu_srs_pkg::ACCEL_READ_BYTES;
      end else if (temp_st[imu_srs_pkg::ST_PEND] && !gyro_st[imu_srs_pkg::ST_XFER]
                   && !accel_st[imu_srs_pkg::ST_XFER]) begin
        temp_st[imu_srs_pkg::ST_PEND] = 1'b0;
        temp_st[imu_srs_pkg::ST_XFER] = 1'b1;
        accel_cs          = 1'b1;
        r.start_valid     = 1'b1;
        r.start_source    = imu_srs_pkg::SRC_TEMP;
        r.command_byte    = imu_srs_pkg::CMD_TEMP;
        r.transfer_length = imu_srs_pkg::TEMP_READ_BYTES;
      end
    endfunction

    function void note_event(imu_srs_pkg::mode_e mode, logic busy);
      imu_srs_pkg::result_t r;
      r = '0;
      case (mode)
        imu_srs_pkg::MODE_ACCEL_IRQ: begin
          accel_st[imu_srs_pkg::ST_PEND] = 1'b1;
          temp_st[imu_srs_pkg::ST_PEND]  = 1'b1;
          if (sched_en) try_start(busy, r);
        end
        imu_srs_pkg::MODE_GYRO_IRQ: begin
          gyro_st[imu_srs_pkg::ST_PEND] = 1'b1;
          if (sched_en) try_start(busy, r);
        end
        imu_srs_pkg::MODE_XFER_DONE: begin
          if (gyro_st[imu_srs_pkg::ST_XFER]) begin
            gyro_st[imu_srs_pkg::ST_XFER] = 1'b0;
            gyro_st[imu_srs_pkg::ST_UPD]  = 1'b1;
            gyro_cs          = 1'b0;
          end
          if (accel_st[imu_srs_pkg::ST_XFER]) begin
            accel_st[imu_srs_pkg::ST_XFER] = 1'b0;
            accel_st[imu_srs_pkg::ST_UPD]  = 1'b1;
            accel_cs          = 1'b0;
          end
          if (temp_st[imu_srs_pkg::ST_XFER]) begin
            temp_st[imu_srs_pkg::ST_XFER] = 1'b0;
            temp_st[imu_srs_pkg::ST_UPD]  = 1'b1;
            accel_cs         = 1'b0;
          end
          // completion schedules even with scheduling disabled
          try_start(busy, r);
          if (gyro_st[imu_srs_pkg::ST_UPD]) begin
            gyro_st[imu_srs_pkg::ST_UPD]  = 1'b0;
            gyro_st[imu_srs_pkg::ST_NOTE] = 1'b1;
            r.wake_task      = 1'b1;
          end
        end
        imu_srs_pkg::MODE_CONSUME: begin
          if (gyro_st[imu_srs_pkg::ST_NOTE]) begin
            gyro_st[imu_srs_pkg::ST_NOTE] = 1'b0;
            r.gyro_delivered = 1'b1;
          end
          if (accel_st[imu_srs_pkg::ST_UPD]) begin
            accel_st[imu_srs_pkg::ST_UPD] = 1'b0;
            r.accel_delivered = 1'b1;
          end
          if (temp_st[imu_srs_pkg::ST_UPD]) begin
            temp_st[imu_srs_pkg::ST_UPD] = 1'b0;
            r.temp_delivered = 1'b1;
          end
        end
        default: ;
      endcase
      r.gyro_select_active  = gyro_cs;
      r.accel_select_active = accel_cs;
      expected_q.push_back(r);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                  checked, name, got, want));
      end
    endtask

    task check_result(imu_srs_pkg::result_t got);
      imu_srs_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no event waiting");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      check_field("start_valid", 8'(got.start_valid), 8'(want.start_valid));
      check_field("start_source", 8'(got.start_source), 8'(want.start_source));
      check_field("command_byte", got.command_byte, want.command_byte);
      check_field("transfer_length", 8'(got.transfer_length),
                  8'(want.transfer_length));
      check_field("gyro_select_active", 8'(got.gyro_select_active),
                  8'(want.gyro_select_active));
      check_field("accel_select_active", 8'(got.accel_select_active),
                  8'(want.accel_select_active));
      check_field("wake_task", 8'(got.wake_task), 8'(want.wake_task));
      check_field("gyro_delivered", 8'(got.gyro_delivered), 8'(want.gyro_delivered));
      check_field("accel_delivered", 8'(got.accel_delivered),
                  8'(want.accel_delivered));
      check_field("temp_delivered", 8'(got.temp_delivered), 8'(want.temp_delivered));
    endtask
  endclass

endpackage

FILE: tb/tb_imu_spi_read_scheduler_top.sv
`timescale 1ns / 1ps
// testbench for imu_spi_read_scheduler_top: directed and random event streams
// with random idling on both sides. depends on imu_srs_pkg and imu_srs_tb_pkg
module tb_imu_spi_read_scheduler_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 140;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] mode_i      = imu_srs_pkg::MODE_ACCEL_IRQ;
  logic       link_busy_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       start_valid_o;
  logic [1:0] start_source_o;
  logic [7:0] command_byte_o;
  logic [3:0] transfer_length_o;
  logic       gyro_select_active_o;
  logic       accel_select_active_o;
  logic       wake_task_o;
  logic       gyro_delivered_o;
  logic       accel_delivered_o;
  logic       temp_delivered_o;

  imu_srs_pkg::result_t                 observed;
  imu_srs_tb_pkg::read_sched_scoreboard sb;
  bit                                   calm = 1'b0;
  int unsigned                          cycles = 0;

  assign observed = {start_valid_o, start_source_o, command_byte_o, transfer_length_o,
                     gyro_select_active_o, accel_select_active_o, wake_task_o,
                     gyro_delivered_o, accel_delivered_o, temp_delivered_o};

  imu_spi_read_scheduler_top DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .mode_i                (mode_i),
    .link_busy_i           (link_busy_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .start_valid_o         (start_valid_o),
    .start_source_o        (start_source_o),
    .command_byte_o        (command_byte_o),
    .transfer_length_o     (transfer_length_o),
    .gyro_select_active_o  (gyro_select_active_o),
    .accel_select_active_o (accel_select_active_o),
    .wake_task_o           (wake_task_o),
    .gyro_delivered_o      (gyro_delivered_o),
    .accel_delivered_o     (accel_delivered_o),
    .temp_delivered_o      (temp_delivered_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_event(imu_srs_pkg::mode_e mode, logic busy);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    link_busy_i <= busy;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(mode, busy);
  endtask

  // mostly plausible event mix, some uniform noise
  task automatic send_random_event();
    int unsigned pick;
    logic        busy;
    pick = $urandom_range(0, 99);
    busy = ($urandom_range(0, 99) < 20);
    if (pick < 10) begin
      send_event(imu_srs_pkg::mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    else if (pick < 35) send_event(imu_srs_pkg::MODE_GYRO_IRQ, busy);
    else if (pick < 55) send_event(imu_srs_pkg::MODE_ACCEL_IRQ, busy);
    else if (pick < 82) send_event(imu_srs_pkg::MODE_XFER_DONE, busy);
    else send_event(imu_srs_pkg::MODE_CONSUME, busy);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_sched_enable(logic en);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    sb.sched_en = en;
    cfg_we_i <= 1'b0;
  endtask

  // result side: random stall before each result
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(observed);
    end
  end

  initial begin
    do begin
      @(posedge clk_i);
      cycles++;
    end while (cycles < CYCLE_LIMIT);
    $display("imu_spi_read_scheduler_top test failed");
    $finish;
  end

  initial begin
    logic sched_setting [6];
    sched_setting = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scheduling off: interrupts only mark pending, completions still start reads
    write_sched_enable(1'b0);
    send_event(imu_srs_pkg::MODE_ACCEL_IRQ, 1'b0);
    send_event(imu_srs_pkg::MODE_GYRO_IRQ, 1'b1);
    send_event(imu_srs_pkg::MODE_CONSUME, 1'b0);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b1);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_CONSUME, 1'b0);
    hold_until_drained();

    // scheduling on: restart of a source in flight, blocking by other sources
    write_sched_enable(1'b1);
    send_event(imu_srs_pkg::MODE_GYRO_IRQ, 1'b0);
    send_event(imu_srs_pkg::MODE_GYRO_IRQ, 1'b0);
    send_event(imu_srs_pkg::MODE_ACCEL_IRQ, 1'b0);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b1);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_GYRO_IRQ, 1'b0);
    send_event(imu_srs_pkg::MODE_ACCEL_IRQ, 1'b0);
    send_event(imu_srs_pkg::MODE_CONSUME, 1'b1);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_CONSUME, 1'b0);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_XFER_DONE, 1'b0);
    send_event(imu_srs_pkg::MODE_CONSUME, 1'b0);

    for (int p = 0; p < 6; p++) begin
      hold_until_drained();
      write_sched_enable(sched_setting[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // one phase and a stretch of every phase run back to back
        calm = (p == 2) || (i >= 40 && i < 60);
        send_random_event();
      end
      calm = 1'b0;
    end

    hold_until_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("imu_spi_read_scheduler_top test passed");
    end else begin
      $display("imu_spi_read_scheduler_top test failed");
    end
    $finish;
  end

endmodule

FILE: imu_spi_read_scheduler_top.f
rtl/imu_srs_pkg.sv
rtl/imu_spi_read_scheduler_top.sv
tb/imu_srs_tb_pkg.sv
tb/tb_imu_spi_read_scheduler_top.sv
